FILE: rtl/buzzer_note_sequencer_assert.svh
// Assertion macros used by the buzzer note sequencer RTL.
// Depends on nothing; included by bns_sequencer, which checks its own logic.
`ifndef BUZZER_NOTE_SEQUENCER_ASSERT_SVH
`define BUZZER_NOTE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BNS_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bns_pkg.sv
// Package of the buzzer note sequencer: field widths, opcodes, beat types and states.
// Depends on nothing; the top level, divider and sequencer refer to it by scoped names.
`default_nettype none

package bns_pkg;

  localparam int NOTE_DEPTH_DEF = 1024;
  localparam int SONG_SLOTS_DEF = 8;

  localparam int OPCODE_W = 3;
  localparam int SLOT_W   = 3;
  localparam int ADDR_W   = 10;
  localparam int FREQ_W   = 16;
  localparam int TICKS_W  = 16;
  localparam int LENGTH_W = 11;
  localparam int PERIOD_W = 20;
  localparam int COMPARE_W = 19;

  // Period is 1000000 / f; the compare value 500000 / f equals the period halved.
  localparam logic [PERIOD_W-1:0] PERIOD_NUM = 20'd1000000;

  localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PLAY     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_STOP     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_NOTE_WR  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SONG_WR  = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   song_index;
    logic [ADDR_W-1:0]   note_address;
    logic [FREQ_W-1:0]   note_freq;
    logic [TICKS_W-1:0]  note_ticks;
    logic [ADDR_W-1:0]   song_start;
    logic [LENGTH_W-1:0] song_length;
  } bns_cmd_t;

  typedef struct packed {
    logic                 drive_update;
    logic                 tone_enable;
    logic [PERIOD_W-1:0]  timer_period;
    logic [COMPARE_W-1:0] timer_compare;
    logic                 playing;
  } bns_status_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] divisor;
  } bns_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } bns_div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_CHECK,
    S_PLAY_LOAD,
    S_NOTE_WAIT,
    S_DIVIDE,
    S_FINISH
  } bns_state_t;

endpackage

`default_nettype wire

FILE: rtl/bns_stream_if.sv
// Valid/ready stream interface carrying one payload of type T per beat.
// Depends on nothing; the payload types come from bns_pkg at instantiation.
`default_nettype none

interface bns_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/buzzer_note_sequencer.sv
// Top level of the buzzer note sequencer: player control, divider and result register.
// Depends on bns_pkg, bns_stream_if, bns_divider and bns_sequencer.
//
//   Port    Direction  Beat type
//   cmd     in         bns_pkg::bns_cmd_t     (tick, play, stop, table writes)
//   status  out        bns_pkg::bns_status_t  (one beat per command)
//
// A result goes from the decode state via the finish state into the status register; a tick
// reading the note table also passes the tick check state, a loaded note the note wait state,
// and a new tone the divide state of the 20-step period divider. One command is in progress
// at a time; the next is taken in the idle state after the result enters the output register.
// Reset is synchronous and needs no clearing pass; the tables are undefined until written.
// A stalled status port holds the block after one further result.
`default_nettype none

module buzzer_note_sequencer #(
  parameter int NOTE_DEPTH = bns_pkg::NOTE_DEPTH_DEF,
  parameter int SONG_SLOTS = bns_pkg::SONG_SLOTS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  bns_stream_if.sink   cmd,
  bns_stream_if.source status
);

  bns_pkg::bns_status_t  res;
  bns_pkg::bns_div_req_t div_req;
  bns_pkg::bns_div_rsp_t div_rsp;
  logic                  res_valid;
  logic                  res_ready;
  logic                  out_valid;
  bns_pkg::bns_status_t  out_data;

  bns_sequencer #(
    .NOTE_DEPTH(NOTE_DEPTH),
    .SONG_SLOTS(SONG_SLOTS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  bns_divider u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign res_ready = !out_valid || status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign status.valid = out_valid;
  assign status.data  = out_data;

endmodule

`default_nettype wire

FILE: rtl/bns_divider.sv
// Restoring divider computing 1000000 / divisor, one quotient bit per cycle.
// Depends on bns_pkg for widths, the dividend constant and request/response types.
`default_nettype none

module bns_divider (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bns_pkg::bns_div_req_t req,
  output bns_pkg::bns_div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(bns_pkg::PERIOD_W + 1);

  logic [bns_pkg::PERIOD_W-1:0] work;
  logic [bns_pkg::FREQ_W-1:0]   rem;
  logic [bns_pkg::FREQ_W-1:0]   divr;
  logic [CNT_W-1:0]             count;
  logic                         busy;
  logic                         done;
  logic [bns_pkg::FREQ_W:0]     trial;
  logic                         take;

  assign trial = {rem, work[bns_pkg::PERIOD_W-1]};
  assign take  = trial >= {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(bns_pkg::PERIOD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= bns_pkg::PERIOD_NUM;
      rem  <= '0;
      divr <= req.divisor;
    end else if (busy) begin
      if (take) begin
        rem <= bns_pkg::FREQ_W'(trial - {1'b0, divr});
      end else begin
        rem <= trial[bns_pkg::FREQ_W-1:0];
      end
      work <= {work[bns_pkg::PERIOD_W-2:0], take};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

`default_nettype wire

FILE: rtl/bns_sequencer.sv
// Player control: note and song memories, play state and the per-beat sequencing FSM.
// Depends on bns_pkg, bns_stream_if and the assertion macro header.
`default_nettype none
`include "buzzer_note_sequencer_assert.svh"

module bns_sequencer #(
  parameter int NOTE_DEPTH = bns_pkg::NOTE_DEPTH_DEF,
  parameter int SONG_SLOTS = bns_pkg::SONG_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bns_stream_if.sink                 cmd,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output bns_pkg::bns_status_t       res,
  output bns_pkg::bns_div_req_t      div_req,
  input  wire bns_pkg::bns_div_rsp_t div_rsp
);

  localparam int NOTE_AW   = $clog2(NOTE_DEPTH);
  localparam int SLOT_AW   = (SONG_SLOTS > 1) ? $clog2(SONG_SLOTS) : 1;
  localparam int MOD_STEPS = (NOTE_AW >= bns_pkg::ADDR_W) ? 1 : bns_pkg::ADDR_W + 1 - NOTE_AW;
  localparam logic [16:0] DEPTH_W = 17'(NOTE_DEPTH);
  localparam logic [6:0]  SLOTS_W = 7'(SONG_SLOTS);
  localparam int NOTE_DW = bns_pkg::FREQ_W + bns_pkg::TICKS_W;
  localparam int SONG_DW = bns_pkg::ADDR_W + bns_pkg::LENGTH_W;

  bns_pkg::bns_state_t state, state_next;
  bns_pkg::bns_cmd_t   lat, lat_next;

  logic                          active, active_next;
  logic                          updated, updated_next;
  logic [bns_pkg::LENGTH_W-1:0]  pos, pos_next;
  logic [bns_pkg::LENGTH_W-1:0]  song_end, song_end_next;
  logic [bns_pkg::LENGTH_W-1:0]  pos_inc;
  logic [bns_pkg::TICKS_W-1:0]   elapsed, elapsed_next;
  logic [bns_pkg::PERIOD_W-1:0]  period, period_next;
  logic [bns_pkg::COMPARE_W-1:0] compare, compare_next;
  logic [NOTE_AW-1:0]            cursor, cursor_next, cursor_inc, start_mod;

  logic [NOTE_DW-1:0] note_mem [NOTE_DEPTH];
  logic [SONG_DW-1:0] song_mem [SONG_SLOTS];
  logic [NOTE_DW-1:0] note_q;
  logic [SONG_DW-1:0] song_q;
  logic               note_we, song_we;

  logic [bns_pkg::FREQ_W-1:0]   q_freq;
  logic [bns_pkg::TICKS_W-1:0]  q_ticks;
  logic [bns_pkg::ADDR_W-1:0]   q_start;
  logic [bns_pkg::LENGTH_W-1:0] q_length;
  logic [16:0]                  addr_w, red;
  logic [6:0]                   slot_w;
  logic                         addr_ok, slot_ok;

  assign {q_freq, q_ticks}    = note_q;
  assign {q_start, q_length}  = song_q;
  assign addr_w  = 17'(lat.note_address);
  assign slot_w  = 7'(lat.song_index);
  assign addr_ok = addr_w < DEPTH_W;
  assign slot_ok = slot_w < SLOTS_W;
  assign pos_inc = pos + 1'b1;
  assign cursor_inc = (cursor == NOTE_AW'(NOTE_DEPTH - 1)) ? '0 : cursor + 1'b1;

  // The start entry is reduced modulo the note depth by shifted compare and subtract.
  always_comb begin
    red = 17'(q_start);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (red >= (DEPTH_W << k)) begin
        red = red - (DEPTH_W << k);
      end
    end
    start_mod = red[NOTE_AW-1:0];
  end

  // Each item is handled alone, so a table write never coincides with a command that uses the read data.
  always_ff @(posedge clk) begin
    if (note_we) begin
      note_mem[addr_w[NOTE_AW-1:0]] <= {lat.note_freq, lat.note_ticks};
    end
    note_q <= note_mem[cursor_next];
  end

  always_ff @(posedge clk) begin
    if (song_we) begin
      song_mem[slot_w[SLOT_AW-1:0]] <= {lat.song_start, lat.song_length};
    end
    song_q <= song_mem[slot_w[SLOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bns_pkg::S_IDLE;
      active   <= 1'b0;
      updated  <= 1'b0;
      pos      <= '0;
      song_end <= '0;
      elapsed  <= '0;
      period   <= '0;
      compare  <= '0;
      cursor   <= '0;
    end else begin
      state    <= state_next;
      active   <= active_next;
      updated  <= updated_next;
      pos      <= pos_next;
      song_end <= song_end_next;
      elapsed  <= elapsed_next;
      period   <= period_next;
      compare  <= compare_next;
      cursor   <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    lat <= lat_next;
  end

  always_comb begin
    state_next      = state;
    lat_next        = lat;
    active_next     = active;
    updated_next    = updated;
    pos_next        = pos;
    song_end_next   = song_end;
    elapsed_next    = elapsed;
    period_next     = period;
    compare_next    = compare;
    cursor_next     = cursor;
    note_we         = 1'b0;
    song_we         = 1'b0;
    cmd.ready       = 1'b0;
    res_valid       = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = q_freq;

    unique case (state)
      bns_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          lat_next     = cmd.data;
          updated_next = 1'b0;
          state_next   = bns_pkg::S_DECODE;
        end
      end
      bns_pkg::S_DECODE: begin
        state_next = bns_pkg::S_FINISH;
        unique case (lat.opcode)
          bns_pkg::OP_TICK: begin
            if (active) begin
              state_next = bns_pkg::S_TICK_CHECK;
            end
          end
          bns_pkg::OP_PLAY: begin
            if (slot_ok) begin
              state_next = bns_pkg::S_PLAY_LOAD;
            end
          end
          bns_pkg::OP_STOP: begin
            active_next  = 1'b0;
            compare_next = '0;
            updated_next = 1'b1;
          end
          bns_pkg::OP_NOTE_WR: begin
            note_we = addr_ok;
          end
          bns_pkg::OP_SONG_WR: begin
            song_we = slot_ok;
          end
          default: begin
            state_next = bns_pkg::S_FINISH;
          end
        endcase
      end
      bns_pkg::S_TICK_CHECK: begin
        state_next = bns_pkg::S_FINISH;
        if (elapsed >= q_ticks) begin
          elapsed_next = bns_pkg::TICKS_W'(1);
          pos_next     = pos_inc;
          cursor_next  = cursor_inc;
          updated_next = 1'b1;
          if (pos_inc >= song_end) begin
            active_next  = 1'b0;
            compare_next = '0;
          end else begin
            state_next = bns_pkg::S_NOTE_WAIT;
          end
        end else begin
          elapsed_next = elapsed + 1'b1;
        end
      end
      bns_pkg::S_PLAY_LOAD: begin
        cursor_next   = start_mod;
        pos_next      = '0;
        song_end_next = q_length;
        active_next   = 1'b1;
        updated_next  = 1'b1;
        state_next    = bns_pkg::S_NOTE_WAIT;
      end
      bns_pkg::S_NOTE_WAIT: begin
        if (q_freq == '0) begin
          compare_next = '0;
          state_next   = bns_pkg::S_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_next    = bns_pkg::S_DIVIDE;
        end
      end
      bns_pkg::S_DIVIDE: begin
        if (div_rsp.done) begin
          period_next  = div_rsp.quotient;
          compare_next = div_rsp.quotient[bns_pkg::PERIOD_W-1:1];
          state_next   = bns_pkg::S_FINISH;
        end
      end
      bns_pkg::S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bns_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bns_pkg::S_IDLE;
      end
    endcase
  end

  assign res.drive_update  = updated;
  assign res.tone_enable   = compare != '0;
  assign res.timer_period  = period;
  assign res.timer_compare = compare;
  assign res.playing       = active;

  `BNS_ASSERT(a_compare_has_period, clk, rst, compare != '0, period != '0, "tone without period")
  `BNS_ASSERT(a_div_start_free, clk, rst, div_req.start, !div_rsp.busy, "divider restarted")
  `BNS_ASSERT_NEXT(a_stop_silences, clk, rst, state == bns_pkg::S_DECODE && lat.opcode == bns_pkg::OP_STOP, !active && compare == '0, "stop left tone on")

endmodule

`default_nettype wire
